// ===== hw/rtl/utf8_sanitizer_assert.svh =====
// assertion macros for the utf8 sanitizer checker
`ifndef UTF8_SANITIZER_ASSERT_SVH
`define UTF8_SANITIZER_ASSERT_SVH

// clocked check, quiet while reset is applied
`define U8S_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define U8S_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/utf8s_pkg.sv =====
// shared types, constants and helper functions of the utf8 sanitizer
package utf8s_pkg;

	localparam logic [7:0] REP_B0 = 8'hEF;
	localparam logic [7:0] REP_B1 = 8'hBF;
	localparam logic [7:0] REP_B2 = 8'hBD;
	localparam logic [7:0] LEAD_MAX = 8'hF4;
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// one input beat worth of work: replacements first, then an optional passed unit
	typedef struct packed {
		logic [2:0] nrep;
		logic has_pass;
		logic [1:0] plen;
		logic [3:0][7:0] pbytes;
		logic [31:0] base_count;
		logic base_inv;
		logic eos;
	} entry_t;

	function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [2:0] k);
		logic [32:0] s;
		s = {1'b0, x} + {30'b0, k};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic [2:0] seq_need(input logic [7:0] lead);
		logic [2:0] n;
		if (lead[7:5] == 3'b110) begin
			n = 3'd2;
		end else if (lead[7:4] == 4'b1110) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic seq_bad(input logic [7:0] lead, input logic [7:0] b1,
			input logic [2:0] need);
		logic bad;
		case (need)
			3'd2: bad = (lead[4:1] == 4'd0);
			3'd3: bad = (lead[3:0] == 4'd0) && !b1[5];
			default: bad = ((lead[2:0] == 3'd0) && (b1[5:4] == 2'd0)) ||
				((lead == LEAD_MAX) && (b1[5:4] != 2'd0));
		endcase
		return bad;
	endfunction

endpackage

// ===== hw/rtl/utf8s_in_if.sv =====
// raw byte channel
interface utf8s_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== hw/rtl/utf8s_out_if.sv =====
// cleaned byte channel
interface utf8s_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_of_run;
	logic string_done;
	logic any_invalid;
	logic [31:0] code_points;

	modport source (output valid, output out_byte, output last_of_run, output string_done,
		output any_invalid, output code_points, input ready);
	modport sink (input valid, input out_byte, input last_of_run, input string_done,
		input any_invalid, input code_points, output ready);
endinterface

// ===== hw/rtl/utf8s_front.sv =====
// front end: accepts raw beats, tracks pending sequence state, builds work entries
module utf8s_front (
	input logic clk,
	input logic arst_n,
	utf8s_in_if.sink raw,
	input logic full,
	output logic push,
	output utf8s_pkg::entry_t entry
);
	import utf8s_pkg::*;

	logic [7:0] held0_q, held1_q, held2_q;
	logic [1:0] held_cnt_q;
	logic inv_q;
	logic [31:0] pc_q;

	logic accept, cont, completes, stored_lead, store_cont;
	logic [7:0] b;
	logic [2:0] need, nrep;
	logic [1:0] held_cnt_d;
	logic has_pass;
	logic [1:0] plen;
	logic [3:0][7:0] pbytes;

	assign raw.ready = !full;
	assign accept = raw.valid && raw.ready;
	assign b = raw.in_byte;
	assign cont = (b[7:6] == 2'b10);
	assign need = seq_need(held0_q);
	assign completes = ({1'b0, held_cnt_q} + 3'd1) >= need;

	always_comb begin
		nrep = 3'd0;
		has_pass = 1'b0;
		plen = 2'd0;
		pbytes = {b, b, b, b};
		held_cnt_d = 2'd0;
		stored_lead = 1'b0;
		store_cont = 1'b0;
		if ((held_cnt_q != 2'd0) && cont) begin
			if (completes) begin
				pbytes[0] = held0_q;
				pbytes[1] = (held_cnt_q == 2'd1) ? b : held1_q;
				pbytes[2] = (held_cnt_q == 2'd2) ? b : held2_q;
				pbytes[3] = b;
				if (seq_bad(held0_q, pbytes[1], need)) begin
					nrep = 3'd1;
				end else begin
					has_pass = 1'b1;
					plen = 2'(need - 3'd1);
				end
			end else begin
				store_cont = 1'b1;
				held_cnt_d = held_cnt_q + 2'd1;
				if (raw.end_of_string) begin
					nrep = {1'b0, held_cnt_q} + 3'd1;
				end
			end
		end else begin
			nrep = {1'b0, held_cnt_q};
			if (b < ASCII_LIMIT) begin
				has_pass = 1'b1;
			end else if (cont || (b > LEAD_MAX)) begin
				nrep = nrep + 3'd1;
			end else begin
				stored_lead = 1'b1;
				held_cnt_d = 2'd1;
				if (raw.end_of_string) begin
					nrep = nrep + 3'd1;
				end
			end
		end
	end

	assign push = accept && ((nrep != 3'd0) || has_pass);

	always_comb begin
		entry.nrep = nrep;
		entry.has_pass = has_pass;
		entry.plen = plen;
		entry.pbytes = pbytes;
		entry.base_count = pc_q;
		entry.base_inv = inv_q;
		entry.eos = raw.end_of_string;
	end

	always_ff @(posedge clk) begin
		if (accept && stored_lead) begin
			held0_q <= b;
		end
		if (accept && store_cont && (held_cnt_q == 2'd1)) begin
			held1_q <= b;
		end
		if (accept && store_cont && (held_cnt_q == 2'd2)) begin
			held2_q <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			inv_q <= 1'b0;
			pc_q <= '0;
		end else if (accept) begin
			if (raw.end_of_string) begin
				held_cnt_q <= 2'd0;
				inv_q <= 1'b0;
				pc_q <= '0;
			end else begin
				held_cnt_q <= held_cnt_d;
				inv_q <= inv_q | (nrep != 3'd0);
				pc_q <= sat_add(pc_q, nrep + {2'b0, has_pass});
			end
		end
	end

endmodule

// ===== hw/rtl/utf8s_queue.sv =====
// short queue of work entries between front and back
module utf8s_queue #(
	parameter int unsigned DEPTH = utf8s_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input utf8s_pkg::entry_t wr_data,
	output logic full,
	input logic rd_en,
	output utf8s_pkg::entry_t rd_data,
	output logic not_empty
);
	import utf8s_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && not_empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/utf8s_back.sv =====
// back end: walks an entry unit by unit and drives the output register
module utf8s_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input utf8s_pkg::entry_t head,
	output logic pop,
	utf8s_out_if.source clean
);
	import utf8s_pkg::*;

	logic [2:0] unit_q;
	logic [1:0] byte_q;
	logic [31:0] run_q;

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic last_q, done_q, inv_q;
	logic [31:0] cnt_q;

	logic advance, is_rep, unit_last, entry_last, inv;
	logic [31:0] prev, cnt;
	logic [7:0] obyte;

	assign advance = head_valid && (!out_valid_q || clean.ready);
	assign is_rep = (unit_q < head.nrep);
	assign unit_last = is_rep ? (byte_q == 2'd2) : (byte_q == head.plen);
	assign entry_last = unit_last &&
		(!is_rep || ((unit_q == head.nrep - 3'd1) && !head.has_pass));
	assign prev = (unit_q == 3'd0) ? head.base_count : run_q;
	assign cnt = (byte_q == 2'd0) ? sat_add(prev, 3'd1) : run_q;
	assign inv = is_rep | head.base_inv | (head.nrep != 3'd0);
	assign pop = advance && entry_last;

	always_comb begin
		if (is_rep) begin
			case (byte_q)
				2'd0: obyte = REP_B0;
				2'd1: obyte = REP_B1;
				default: obyte = REP_B2;
			endcase
		end else begin
			obyte = head.pbytes[byte_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= 3'd0;
			byte_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (entry_last) begin
					unit_q <= 3'd0;
					byte_q <= 2'd0;
				end else if (unit_last) begin
					unit_q <= unit_q + 3'd1;
					byte_q <= 2'd0;
				end else begin
					byte_q <= byte_q + 2'd1;
				end
			end else if (clean.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			run_q <= cnt;
			out_byte_q <= obyte;
			last_q <= entry_last;
			done_q <= entry_last && head.eos;
			inv_q <= inv;
			cnt_q <= cnt;
		end
	end

	assign clean.valid = out_valid_q;
	assign clean.out_byte = out_byte_q;
	assign clean.last_of_run = last_q;
	assign clean.string_done = done_q;
	assign clean.any_invalid = inv_q;
	assign clean.code_points = cnt_q;

endmodule

// ===== hw/rtl/utf8_sanitizer.sv =====
// top level of the streaming utf8 sanitizer
//
//   channel  dir  payload                                              beat
//   raw      in   in_byte, end_of_string                               one source byte
//   clean    out  out_byte, last_of_run, string_done, any_invalid,     one cleaned byte
//                 code_points
//
// a raw beat is taken every cycle while the entry queue has room
// each raw beat gives the back end 0 to 12 output bytes, sent one per clean handshake
// a raw beat reaches clean through the entry queue and then the output register
// reset clears pending sequence state, queue and output valid flag
// stalls on clean back up through the queue to raw.ready
module utf8_sanitizer #(
	parameter int unsigned QUEUE_DEPTH = utf8s_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	utf8s_in_if.sink raw,
	utf8s_out_if.source clean
);
	import utf8s_pkg::*;

	entry_t wr_entry, rd_entry;
	logic push, full, pop, not_empty;

	utf8s_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw),
		.full(full),
		.push(push),
		.entry(wr_entry)
	);

	utf8s_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push),
		.wr_data(wr_entry),
		.full(full),
		.rd_en(pop),
		.rd_data(rd_entry),
		.not_empty(not_empty)
	);

	utf8s_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(not_empty),
		.head(rd_entry),
		.pop(pop),
		.clean(clean)
	);

endmodule

// ===== hw/rtl/utf8s_checker.sv =====
// port-level checks of the utf8 sanitizer and their binding
`include "utf8_sanitizer_assert.svh"

module utf8s_checker (
	input logic clk,
	input logic arst_n,
	input logic clean_valid,
	input logic clean_ready,
	input logic [7:0] clean_out_byte,
	input logic clean_last_of_run,
	input logic clean_string_done,
	input logic clean_any_invalid,
	input logic [31:0] clean_code_points
);

	logic beat;
	logic have_q, prev_done_q, prev_inv_q;
	logic [31:0] prev_cnt_q;

	assign beat = clean_valid && clean_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			prev_done_q <= 1'b0;
			prev_inv_q <= 1'b0;
			prev_cnt_q <= '0;
		end else if (beat) begin
			have_q <= 1'b1;
			prev_done_q <= clean_string_done;
			prev_inv_q <= clean_any_invalid;
			prev_cnt_q <= clean_code_points;
		end
	end

	// no beat offered while in reset
	`U8S_ASSERT_RST(a_reset_quiet, !arst_n |-> !clean_valid, "clean valid during reset")

	// stalled beat holds its payload
	`U8S_ASSERT_CLK(a_stall_hold, clean_valid && !clean_ready |=> clean_valid && $stable(clean_out_byte) && $stable(clean_code_points), "stalled clean beat changed")

	// end of string closes the run
	`U8S_ASSERT_CLK(a_done_last, clean_valid && clean_string_done |-> clean_last_of_run, "string_done without last_of_run")

	// count starts at one and grows by at most one per byte
	`U8S_ASSERT_CLK(a_count_step, beat |-> ((have_q && !prev_done_q) ? ((clean_code_points == prev_cnt_q) || (clean_code_points == prev_cnt_q + 32'd1)) : (clean_code_points == 32'd1)), "code point count jumped")

	// invalid flag sticks until the string ends
	`U8S_ASSERT_CLK(a_inv_sticky, beat && have_q && !prev_done_q && prev_inv_q |-> clean_any_invalid, "any_invalid dropped inside a string")

endmodule

bind utf8_sanitizer utf8s_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.clean_valid(clean.valid),
	.clean_ready(clean.ready),
	.clean_out_byte(clean.out_byte),
	.clean_last_of_run(clean.last_of_run),
	.clean_string_done(clean.string_done),
	.clean_any_invalid(clean.any_invalid),
	.clean_code_points(clean.code_points)
);
